// ----- design/scol_pkg.sv -----
// Package for the shape collision test: widths, shape kind codes and the
// record that the front end hands to the back end. No dependencies.
`default_nettype none
package scol_pkg;

    localparam int CW = 24;               // coordinate width
    localparam int SW = CW - 1;           // size and margin width
    localparam int DW = CW + 1;           // coordinate difference width
    localparam int RW = 16;               // rotation term width
    localparam int RF = 14;               // rotation fraction bits
    localparam int PW = RW + DW + 1;      // rotated sum width
    localparam int XW = PW - RF;          // rounded local coordinate width
    localparam int QW = 2 * XW;           // squared local width
    localparam int AW = 2 * (SW + 1);     // squared (size + margin) width
    localparam int TW = SW + XW + 2;      // triangle edge term width
    localparam int WW = 104;              // wide compare width

    localparam logic [2:0] KIND_CIRCLE   = 3'd0;
    localparam logic [2:0] KIND_BIG      = 3'd1;
    localparam logic [2:0] KIND_RECT     = 3'd2;
    localparam logic [2:0] KIND_TRIANGLE = 3'd3;
    localparam logic [2:0] KIND_ELLIPSE  = 3'd4;
    localparam logic [2:0] KIND_SQUARE   = 3'd5;

    typedef struct packed {
        logic [2:0]           kind;
        logic signed [DW-1:0] ex;
        logic signed [DW-1:0] ey;
        logic [SW-1:0]        a;
        logic [SW-1:0]        b;
        logic [SW-1:0]        m;
        logic signed [RW-1:0] c;
        logic signed [RW-1:0] s;
        logic                 box;
    } front_t;

endpackage
`default_nettype wire

// ----- design/scol_req_if.sv -----
// Request channel of the shape collision test.
// Depends on scol_pkg.
`default_nettype none
interface scol_req_if;
    import scol_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [2:0]           req_type;
    logic signed [CW-1:0] obj_x;
    logic signed [CW-1:0] obj_y;
    logic signed [CW-1:0] aim_x;
    logic signed [CW-1:0] aim_y;
    logic [SW-1:0]        size_a;
    logic [SW-1:0]        size_b;
    logic signed [RW-1:0] rot_cos;
    logic signed [RW-1:0] rot_sin;
    logic [SW-1:0]        margin;

    modport source (output valid, req_type, obj_x, obj_y, aim_x, aim_y, size_a, size_b,
                    rot_cos, rot_sin, margin, input ready);
    modport sink (input valid, req_type, obj_x, obj_y, aim_x, aim_y, size_a, size_b,
                  rot_cos, rot_sin, margin, output ready);
endinterface
`default_nettype wire

// ----- design/scol_rsp_if.sv -----
// Response channel of the shape collision test.
// Depends on scol_pkg.
`default_nettype none
interface scol_rsp_if;
    import scol_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic signed [CW-1:0] local_x;
    logic signed [CW-1:0] local_y;

    modport source (output valid, hit, local_x, local_y, input ready);
    modport sink (input valid, hit, local_x, local_y, output ready);
endinterface
`default_nettype wire

// ----- design/scol_front.sv -----
// Front end: takes a request, forms the offsets and applies the coarse box reject.
// Depends on scol_pkg and scol_req_if.
`default_nettype none
module scol_front (
    scol_req_if.sink          req,
    input  wire logic         full,
    output logic              push,
    output scol_pkg::front_t  item
);
    import scol_pkg::*;

    logic signed [DW-1:0] dx, dy;
    logic [DW-1:0]        adx, ady;
    logic [SW-1:0]        big_l, h;
    logic [SW:0]          am, lm, hm;
    logic [DW-1:0]        ex_m, ey_m;
    logic [2*DW-1:0]      ex2, ey2;
    logic [2*SW-1:0]      l_sq;
    logic [2*SW:0]        l2x2;
    logic                 diag_x, diag_y, circ_box, ell_box, sq_hit, diag_box;

    assign req.ready = !full;
    assign push      = req.valid && !full;

    always_comb
    begin
        dx  = DW'(req.obj_x) - DW'(req.aim_x);
        dy  = DW'(req.obj_y) - DW'(req.aim_y);
        adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
        ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
        big_l = (req.size_a > req.size_b) ? req.size_a : req.size_b;
        h     = (req.size_b == '0) ? req.size_a : req.size_b;
        am = (SW+1)'(req.size_a) + (SW+1)'(req.margin);
        lm = (SW+1)'(big_l) + (SW+1)'(req.margin);
        hm = (SW+1)'(h) + (SW+1)'(req.margin);
        ex_m = adx - DW'(req.margin);
        ey_m = ady - DW'(req.margin);
        ex2  = ex_m * ex_m;
        ey2  = ey_m * ey_m;
        l_sq = big_l * big_l;
        l2x2 = {l_sq, 1'b0};
        // Diagonal reject: |d| against the longer half-size times root two plus margin.
        diag_x = (adx <= DW'(req.margin)) || (ex2 <= (2*DW)'(l2x2));
        diag_y = (ady <= DW'(req.margin)) || (ey2 <= (2*DW)'(l2x2));
        circ_box = (adx <= DW'(req.size_a)) && (ady <= DW'(req.size_a));
        ell_box  = (adx <= DW'(lm)) && (ady <= DW'(lm));
        sq_hit   = (adx <= DW'(am)) && (ady <= DW'(hm));
        diag_box = diag_x && diag_y;

        item.kind = req.req_type;
        item.ex   = DW'(req.aim_x) - DW'(req.obj_x);
        item.ey   = DW'(req.aim_y) - DW'(req.obj_y);
        item.a    = req.size_a;
        item.b    = req.size_b;
        item.m    = req.margin;
        item.c    = req.rot_cos;
        item.s    = req.rot_sin;
        case (req.req_type)
            KIND_CIRCLE, KIND_BIG:   item.box = circ_box;
            KIND_RECT, KIND_TRIANGLE: item.box = diag_box;
            KIND_ELLIPSE:            item.box = ell_box;
            KIND_SQUARE:             item.box = sq_hit;
            default:                 item.box = 1'b0;
        endcase
    end
endmodule
`default_nettype wire

// ----- design/scol_queue.sv -----
// Four-entry queue between the front and back ends.
// Depends on scol_pkg.
`default_nettype none
module scol_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire scol_pkg::front_t  wdata,
    output logic                   full,
    input  wire logic              pop,
    output scol_pkg::front_t       rdata,
    output logic                   empty
);
    import scol_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTRW  = $clog2(DEPTH);

    front_t          mem_reg [DEPTH];
    logic [PTRW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [PTRW:0]   cnt_reg, cnt_next;
    logic            do_pop;

    assign full   = (cnt_reg == (PTRW+1)'(DEPTH));
    assign empty  = (cnt_reg == '0);
    assign rdata  = mem_reg[rd_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (PTRW+1)'(push) - (PTRW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= wdata;
        end
    end
endmodule
`default_nettype wire

// ----- design/scol_back.sv -----
// Back end: six-stage pipeline for rotation, squares and the exact wide tests.
// The last stage is the response register. Depends on scol_pkg and scol_rsp_if.
`default_nettype none
module scol_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire scol_pkg::front_t  item,
    input  wire logic              item_valid,
    output logic                   pop,
    scol_rsp_if.source             rsp
);
    import scol_pkg::*;

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    // stage 1
    logic [2:0]              k1_reg;
    logic                    box1_reg;
    logic [SW-1:0]           a1_reg, b1_reg, m1_reg;
    logic signed [PW-2:0]    pxs_reg, pxc_reg, pyc_reg, pys_reg;
    logic signed [2*DW-1:0]  dx2_reg, dy2_reg;
    logic [2*SW-1:0]         asq1_reg;
    logic [SW:0]             am1_reg, bm1_reg;
    // stage 2
    logic [2:0]              k2_reg;
    logic                    box2_reg, he2_reg;
    logic [SW-1:0]           a2_reg, b2_reg, m2_reg;
    logic signed [XW-1:0]    x2_reg, y2_reg;
    logic [SW:0]             am2_reg, bm2_reg;
    logic [AW-1:0]           aa2_reg, bb2_reg;
    logic [2*SW-1:0]         asq2_reg, bsq2_reg, mm2_reg;
    // stage 3
    logic [2:0]              k3_reg;
    logic                    box3_reg, he3_reg, inr3_reg, mz3_reg;
    logic [QW-1:0]           xq3_reg, yq3_reg;
    logic signed [TW-2:0]    ay3_reg, bx3_reg;
    logic [2*SW:0]           ss3_reg;
    logic [AW-1:0]           aa3_reg, bb3_reg;
    logic [2*SW-1:0]         mm3_reg;
    logic signed [CW-1:0]    lx3_reg, ly3_reg;
    // stage 4
    logic [2:0]              k4_reg;
    logic                    box4_reg, he4_reg, inr4_reg, mz4_reg;
    logic signed [TW-1:0]    t4_reg;
    logic [51:0]             pe_reg [12];
    logic [47:0]             po_reg [4];
    logic signed [CW-1:0]    lx4_reg, ly4_reg;
    // stage 5
    logic [2:0]              k5_reg;
    logic                    box5_reg, he5_reg, inr5_reg, mz5_reg, tn5_reg, ell5_reg;
    logic [WW-1:0]           off5_reg;
    logic [51:0]             pt_reg [4];
    logic signed [CW-1:0]    lx5_reg, ly5_reg;
    // stage 6 (response)
    logic                    hit_reg;
    logic signed [CW-1:0]    lx6_reg, ly6_reg;

    // combinational helpers
    logic signed [PW-1:0]    sx, sy;
    logic [WW-1:0]           dsum, lhs, rhs, tt;
    logic                    circ, big_in;
    logic [XW-1:0]           absx, absy;
    logic signed [CW-1:0]    satx, saty;
    logic                    rotk;
    logic [QW-1:0]           b2e, a2e;
    logic [TW-2:0]           tmag;
    logic [47:0]             mm48, ss48;
    logic                    hit_final;

    assign adv = !v6_reg || rsp.ready;
    assign pop = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= item_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_comb
    begin
        // Round to nearest with ties upward, then drop the rotation fraction.
        sx = PW'(pxs_reg) - PW'(pxc_reg) + PW'(1 <<< (RF - 1));
        sy = PW'(pyc_reg) + PW'(pys_reg) + PW'(1 <<< (RF - 1));
        dsum = WW'(dx2_reg) + WW'(dy2_reg);
        circ = dsum <= WW'(asq1_reg);
        big_in = ({dx2_reg, 1'b0} <= (2*DW+1)'(asq1_reg))
              && ({dy2_reg, 1'b0} <= (2*DW+1)'(asq1_reg));
        rotk = (k2_reg == KIND_RECT) || (k2_reg == KIND_TRIANGLE)
            || (k2_reg == KIND_ELLIPSE);
        absx = x2_reg[XW-1] ? XW'(-x2_reg) : XW'(x2_reg);
        absy = y2_reg[XW-1] ? XW'(-y2_reg) : XW'(y2_reg);
        if (x2_reg > XW'(signed'({1'b0, {(CW-1){1'b1}}})))
            satx = {1'b0, {(CW-1){1'b1}}};
        else if (x2_reg < -XW'(signed'({1'b0, 1'b1, {(CW-1){1'b0}}})))
            satx = {1'b1, {(CW-1){1'b0}}};
        else
            satx = x2_reg[CW-1:0];
        if (y2_reg > XW'(signed'({1'b0, {(CW-1){1'b1}}})))
            saty = {1'b0, {(CW-1){1'b1}}};
        else if (y2_reg < -XW'(signed'({1'b0, 1'b1, {(CW-1){1'b0}}})))
            saty = {1'b1, {(CW-1){1'b0}}};
        else
            saty = y2_reg[CW-1:0];
        b2e  = QW'(bb3_reg);
        a2e  = QW'(aa3_reg);
        mm48 = 48'(mm3_reg);
        ss48 = 48'(ss3_reg);
        tmag = t4_reg[TW-2:0];
        lhs = WW'(pe_reg[0]) + (WW'(pe_reg[1]) << 24) + (WW'(pe_reg[2]) << 28)
            + (WW'(pe_reg[3]) << 52)
            + WW'(pe_reg[4]) + (WW'(pe_reg[5]) << 24) + (WW'(pe_reg[6]) << 28)
            + (WW'(pe_reg[7]) << 52);
        rhs = WW'(pe_reg[8]) + (WW'(pe_reg[9]) << 24) + (WW'(pe_reg[10]) << 24)
            + (WW'(pe_reg[11]) << 48);
        tt = WW'(pt_reg[0]) + (WW'(pt_reg[1]) << 26) + (WW'(pt_reg[2]) << 26)
           + (WW'(pt_reg[3]) << 52);
        case (k5_reg)
            KIND_CIRCLE, KIND_BIG, KIND_SQUARE: hit_final = he5_reg;
            KIND_RECT:     hit_final = box5_reg && inr5_reg;
            KIND_TRIANGLE: hit_final = box5_reg && inr5_reg && !tn5_reg
                                       && (mz5_reg || (off5_reg <= tt));
            KIND_ELLIPSE:  hit_final = box5_reg && ell5_reg;
            default:       hit_final = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1: rotation products and circle squares
            k1_reg   <= item.kind;
            box1_reg <= item.box;
            a1_reg   <= item.a;
            b1_reg   <= item.b;
            m1_reg   <= item.m;
            pxs_reg  <= item.s * item.ex;
            pxc_reg  <= item.c * item.ey;
            pyc_reg  <= item.c * item.ex;
            pys_reg  <= item.s * item.ey;
            dx2_reg  <= item.ex * item.ex;
            dy2_reg  <= item.ey * item.ey;
            asq1_reg <= item.a * item.a;
            am1_reg  <= (SW+1)'(item.a) + (SW+1)'(item.m);
            bm1_reg  <= (SW+1)'(item.b) + (SW+1)'(item.m);
            // stage 2: locals, circle decisions, size squares
            k2_reg   <= k1_reg;
            box2_reg <= box1_reg;
            case (k1_reg)
                KIND_CIRCLE: he2_reg <= box1_reg && circ;
                KIND_BIG:    he2_reg <= box1_reg && (big_in || circ);
                default:     he2_reg <= box1_reg;
            endcase
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            m2_reg   <= m1_reg;
            x2_reg   <= XW'(sx >>> RF);
            y2_reg   <= XW'(sy >>> RF);
            am2_reg  <= am1_reg;
            bm2_reg  <= bm1_reg;
            aa2_reg  <= am1_reg * am1_reg;
            bb2_reg  <= bm1_reg * bm1_reg;
            asq2_reg <= asq1_reg;
            bsq2_reg <= b1_reg * b1_reg;
            mm2_reg  <= m1_reg * m1_reg;
            // stage 3: local squares, rectangle test, triangle edge terms
            k3_reg   <= k2_reg;
            box3_reg <= box2_reg;
            he3_reg  <= he2_reg;
            inr3_reg <= (absx <= XW'(am2_reg)) && (absy <= XW'(bm2_reg));
            mz3_reg  <= (m2_reg == '0);
            xq3_reg  <= QW'(x2_reg * x2_reg);
            yq3_reg  <= QW'(y2_reg * y2_reg);
            ay3_reg  <= $signed({1'b0, a2_reg}) * y2_reg;
            bx3_reg  <= $signed({1'b0, b2_reg}) * x2_reg;
            ss3_reg  <= (2*SW+1)'(asq2_reg) + (2*SW+1)'(bsq2_reg);
            aa3_reg  <= aa2_reg;
            bb3_reg  <= bb2_reg;
            mm3_reg  <= mm2_reg;
            lx3_reg  <= (rotk && box2_reg) ? satx : '0;
            ly3_reg  <= (rotk && box2_reg) ? saty : '0;
            // stage 4: partial products of the wide tests
            k4_reg   <= k3_reg;
            box4_reg <= box3_reg;
            he4_reg  <= he3_reg;
            inr4_reg <= inr3_reg;
            mz4_reg  <= mz3_reg;
            t4_reg   <= TW'(ay3_reg) + TW'(bx3_reg);
            pe_reg[0]  <= 52'(xq3_reg[27:0] * b2e[23:0]);
            pe_reg[1]  <= 52'(xq3_reg[27:0] * b2e[47:24]);
            pe_reg[2]  <= 52'(xq3_reg[QW-1:28] * b2e[23:0]);
            pe_reg[3]  <= 52'(xq3_reg[QW-1:28] * b2e[47:24]);
            pe_reg[4]  <= 52'(yq3_reg[27:0] * a2e[23:0]);
            pe_reg[5]  <= 52'(yq3_reg[27:0] * a2e[47:24]);
            pe_reg[6]  <= 52'(yq3_reg[QW-1:28] * a2e[23:0]);
            pe_reg[7]  <= 52'(yq3_reg[QW-1:28] * a2e[47:24]);
            pe_reg[8]  <= 52'(aa3_reg[23:0] * bb3_reg[23:0]);
            pe_reg[9]  <= 52'(aa3_reg[23:0] * bb3_reg[47:24]);
            pe_reg[10] <= 52'(aa3_reg[47:24] * bb3_reg[23:0]);
            pe_reg[11] <= 52'(aa3_reg[47:24] * bb3_reg[47:24]);
            po_reg[0]  <= mm48[23:0] * ss48[23:0];
            po_reg[1]  <= mm48[23:0] * ss48[47:24];
            po_reg[2]  <= mm48[47:24] * ss48[23:0];
            po_reg[3]  <= mm48[47:24] * ss48[47:24];
            lx4_reg  <= lx3_reg;
            ly4_reg  <= ly3_reg;
            // stage 5: ellipse compare, offset sum, square of the edge term
            k5_reg   <= k4_reg;
            box5_reg <= box4_reg;
            he5_reg  <= he4_reg;
            inr5_reg <= inr4_reg;
            mz5_reg  <= mz4_reg;
            tn5_reg  <= t4_reg[TW-1];
            ell5_reg <= lhs <= rhs;
            off5_reg <= WW'(po_reg[0]) + (WW'(po_reg[1]) << 24) + (WW'(po_reg[2]) << 24)
                      + (WW'(po_reg[3]) << 48);
            pt_reg[0] <= tmag[25:0] * tmag[25:0];
            pt_reg[1] <= tmag[25:0] * tmag[TW-2:26];
            pt_reg[2] <= tmag[TW-2:26] * tmag[25:0];
            pt_reg[3] <= tmag[TW-2:26] * tmag[TW-2:26];
            lx5_reg  <= lx4_reg;
            ly5_reg  <= ly4_reg;
            // stage 6: response register
            hit_reg  <= hit_final;
            lx6_reg  <= lx5_reg;
            ly6_reg  <= ly5_reg;
        end
    end

    assign rsp.valid   = v6_reg;
    assign rsp.hit     = hit_reg;
    assign rsp.local_x = lx6_reg;
    assign rsp.local_y = ly6_reg;
endmodule
`default_nettype wire

// ----- design/shape_collision_test.sv -----
// Point-in-shape collision test: each request gives an object point, a shape
// centre, a shape kind, sizes, a rotation and a margin; each response gives a
// hit flag and the centre offset turned into the shape frame.
// Channels: req (sink) and rsp (source), valid/ready; a request or response
// moves at a rising edge where valid and ready are both high.
// Path: an accepted request enters the four-entry queue at the accepting
// edge; from the queue head it passes through the six pipeline stages of
// the back end, the last of which is the response register.
// Throughput: one request per cycle, set by the pipelined back end whose
// widest products are cut into 28 by 24 bit partial products.
// Responses leave in request order. When rsp.ready is low the back-end
// pipeline holds, the queue fills, and req.ready falls once it holds four
// requests. Reset clears the queue and all valid flags; no response is
// pending after reset and req.ready is high from the first cycle.
// Depends on scol_pkg, scol_req_if, scol_rsp_if, scol_front, scol_queue and
// scol_back.
`default_nettype none
module shape_collision_test (
    input  wire logic  clk,
    input  wire logic  rst_n,
    scol_req_if.sink   req,
    scol_rsp_if.source rsp
);
    import scol_pkg::*;

    front_t item_in, item_out;
    logic   push, full, pop, empty;

    scol_front u_front (
        .req  (req),
        .full (full),
        .push (push),
        .item (item_in)
    );

    scol_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (item_in),
        .full  (full),
        .pop   (pop),
        .rdata (item_out),
        .empty (empty)
    );

    scol_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_out),
        .item_valid (!empty),
        .pop        (pop),
        .rsp        (rsp)
    );
endmodule
`default_nettype wire
